>>> rtl/rm_pkg.sv
// rm_pkg: shared types and constants for the running median block.
// Holds the sample width, the sequencer state type and the per-cell control struct.
// Depends on nothing.
`default_nettype none

package rm_pkg;

  localparam int VALUE_W = 31;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  typedef struct packed {
    logic occupied;  // cell index below the effective count
    logic at_end;    // cell index equals the effective count
    logic sel_lo;    // cell holds the lower middle entry
    logic sel_hi;    // cell holds the upper middle entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/rm_cell.sv
// rm_cell: one slot of the sorted chain; keeps one sample and passes it to its neighbor.
// Takes the new sample, shifts up when the lower neighbor moves, offers its value as a leaf when selected.
// Depends on rm_pkg.
`default_nettype none

module rm_cell (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire rm_pkg::cell_ctrl_t              ctrl,
  input  wire logic [rm_pkg::VALUE_W-1:0]      sample,
  input  wire logic [rm_pkg::VALUE_W-1:0]      prev_value,
  input  wire logic                            prev_gt,
  output logic      [rm_pkg::VALUE_W-1:0]      value,
  output logic                                 gt,
  output logic      [2*rm_pkg::VALUE_W-1:0]    leaf
);

  assign gt = ctrl.occupied && (value > sample);

  always_ff @(posedge clk) begin
    if (load && (gt || ctrl.at_end)) begin
      // shift the lower neighbor up, or take the sample at the insertion point
      value <= prev_gt ? prev_value : sample;
    end
  end

  assign leaf = {ctrl.sel_hi ? value : {rm_pkg::VALUE_W{1'b0}},
                 ctrl.sel_lo ? value : {rm_pkg::VALUE_W{1'b0}}};

endmodule

`default_nettype wire

>>> rtl/rm_tree.sv
// rm_tree: pipelined OR-reduction tree that picks the selected entries out of the chain.
// One register level per tree level plus a leaf register.
// Depends on nothing.
`default_nettype none

module rm_tree #(
  parameter int WIDTH  = 62,
  parameter int LEAVES = 64
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] leaf [LEAVES],
  output logic      [WIDTH-1:0] root
);

  localparam int P = 1 << $clog2(LEAVES);

  logic [WIDTH-1:0] node [2*P-1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < P; j++) begin
      node[P-1+j] <= (j < LEAVES) ? leaf[j] : {WIDTH{1'b0}};
    end
    for (int j = 0; j < P-1; j++) begin
      node[j] <= node[2*j+1] | node[2*j+2];
    end
  end

  assign root = node[0];

endmodule

`default_nettype wire

>>> rtl/running_median.sv
// running_median: running median over a sorted chain of CAPACITY cells.
// The result is registered through the selection tree and presented after the sequencer's
// calculate and load steps; a new sample is taken only while the sequencer is idle, so not
// before the last result is loaded. Insertion itself happens in the accept cycle.
// Reset: clears the sample count, the overflow flag, the sequencer and the output valid; cell contents are kept
// and only entries below the count are ever selected.
`default_nettype none

module running_median #(
  parameter  int CAPACITY = 64,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int OUT_W    = ((rm_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [31:0]      s_tdata,   // [30:0] sample_value, [31] zero
  input  wire logic             s_tuser,   // start_stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,   // median_value, sample_count, zero fill
  output logic                  m_tuser    // store_overflow
);

  localparam int VW    = rm_pkg::VALUE_W;
  localparam int DEPTH = $clog2(CAPACITY);
  localparam int TW    = $clog2(DEPTH + 1);

  rm_pkg::state_t state;
  logic [TW-1:0]  calc_cnt;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [VW-1:0]    m_median;
  logic [CNT_W-1:0] m_count;

  logic             accept;
  logic [CNT_W-1:0] eff_count;
  logic             do_insert;
  logic [CNT_W-1:0] lo_idx;
  logic [CNT_W-1:0] hi_idx;
  logic [VW-1:0]    sample;

  logic [VW-1:0]    cell_value [CAPACITY];
  logic             cell_gt    [CAPACITY];
  logic [2*VW-1:0]  cell_leaf  [CAPACITY];
  logic [2*VW-1:0]  root;
  logic [VW:0]      mid_sum;

  assign s_tready  = (state == rm_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign sample    = s_tdata[VW-1:0];
  assign eff_count = s_tuser ? {CNT_W{1'b0}} : count;
  assign do_insert = eff_count < CNT_W'(CAPACITY);
  assign lo_idx    = (count - CNT_W'(1)) >> 1;
  assign hi_idx    = count >> 1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rm_pkg::cell_ctrl_t ctrl;
    logic [VW-1:0]      prev_value;
    logic               prev_gt;

    assign ctrl.occupied = CNT_W'(i) < eff_count;
    assign ctrl.at_end   = CNT_W'(i) == eff_count;
    assign ctrl.sel_lo   = CNT_W'(i) == lo_idx;
    assign ctrl.sel_hi   = CNT_W'(i) == hi_idx;

    if (i == 0) begin : g_first
      assign prev_value = {VW{1'b0}};
      assign prev_gt    = 1'b0;
    end else begin : g_link
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    rm_cell u_cell (
      .clk        (clk),
      .load       (accept && do_insert),
      .ctrl       (ctrl),
      .sample     (sample),
      .prev_value (prev_value),
      .prev_gt    (prev_gt),
      .value      (cell_value[i]),
      .gt         (cell_gt[i]),
      .leaf       (cell_leaf[i])
    );
  end

  rm_tree #(
    .WIDTH  (2 * VW),
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .root (root)
  );

  assign mid_sum = {1'b0, root[VW-1:0]} + {1'b0, root[2*VW-1:VW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rm_pkg::S_IDLE;
      calc_cnt <= '0;
      count    <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in the load step a new result replaces the one taken
      if (m_tvalid && m_tready && (state != rm_pkg::S_LOAD)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        rm_pkg::S_IDLE: begin
          if (accept) begin
            count    <= do_insert ? eff_count + CNT_W'(1) : eff_count;
            ovf      <= !do_insert;
            calc_cnt <= '0;
            state    <= rm_pkg::S_CALC;
          end
        end
        rm_pkg::S_CALC: begin
          // wait for the leaf register and every tree level to settle
          calc_cnt <= calc_cnt + TW'(1);
          if (calc_cnt == TW'(DEPTH)) begin
            state <= rm_pkg::S_LOAD;
          end
        end
        rm_pkg::S_LOAD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= rm_pkg::S_IDLE;
          end
        end
        default: begin
          state <= rm_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rm_pkg::S_LOAD) && (!m_tvalid || m_tready)) begin
      m_median <= mid_sum[VW:1];
      m_count  <= count;
      m_tuser  <= ovf;
    end
  end

  assign m_tdata = {{(OUT_W - VW - CNT_W){1'b0}}, m_count, m_median};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("sample count above capacity");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (count == CNT_W'(1)))
    else $error("start of stream did not leave exactly one sample");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_count == CNT_W'(CAPACITY)))
    else $error("overflow reported with store not full");

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == rm_pkg::S_LOAD))
    else $error("result presented outside the load step");

endmodule

`default_nettype wire
